>>> rtl/two_class_priority_queue_scheduler_core_macros.svh
// Assertion macros shared by the scheduler RTL.
`ifndef TWO_CLASS_PRIORITY_QUEUE_SCHEDULER_CORE_MACROS_SVH
`define TWO_CLASS_PRIORITY_QUEUE_SCHEDULER_CORE_MACROS_SVH

`ifndef ASSERT_OFF

// Property must hold at every clock edge out of reset.
`define TCPQ_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);

// Condition must never be true out of reset.
`define TCPQ_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) else $error(msg);

`else

`define TCPQ_ASSERT(label, clk, rst_n, prop, msg)
`define TCPQ_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

>>> rtl/tcpq_pkg.sv
// Types and constants shared by the scheduler modules.
package tcpq_pkg;

    localparam int IDENT_W = 10;
    localparam int WAIT_W  = 16;
    localparam int CNT_W   = 32;
    localparam int EVENT_W = 2;

    localparam logic [EVENT_W-1:0] EVENT_IDLE = 2'd0;
    localparam logic [EVENT_W-1:0] EVENT_HIGH = 2'd1;
    localparam logic [EVENT_W-1:0] EVENT_LOW  = 2'd2;

    localparam logic [WAIT_W-1:0] WAIT_MAX = '1;
    localparam logic [CNT_W-1:0]  CNT_MAX  = '1;

    typedef struct packed {
        logic [IDENT_W-1:0] ident;
        logic [WAIT_W-1:0]  wait_cnt;
    } entry_t;

    localparam int ENTRY_W = IDENT_W + WAIT_W;

    typedef enum logic {
        SAT_CNT  = 1'b0,
        SAT_WAIT = 1'b1
    } sat_mode_t;

    typedef struct packed {
        sat_mode_t          mode;
        logic [CNT_W-1:0]   op_a;
        logic [CNT_W-1:0]   op_b;
    } sat_req_t;

endpackage

>>> rtl/tcpq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tcpq_ram #(
    parameter int WIDTH = 26,
    parameter int DEPTH = 8,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/tcpq_sat_add.sv
// Shared saturating adder: 32-bit counter mode or 16-bit wait mode.
module tcpq_sat_add
    import tcpq_pkg::*;
(
    input  sat_req_t         req,
    output logic [CNT_W-1:0] sum
);

    logic [CNT_W:0] raw;

    assign raw = {1'b0, req.op_a} + {1'b0, req.op_b};

    always_comb begin
        unique case (req.mode)
            SAT_WAIT: begin
                sum = (raw[CNT_W:WAIT_W] != '0) ? CNT_W'(WAIT_MAX) : raw[CNT_W-1:0];
            end
            SAT_CNT: begin
                sum = raw[CNT_W] ? CNT_MAX : raw[CNT_W-1:0];
            end
            default: begin
                sum = raw[CNT_W-1:0];
            end
        endcase
    end

endmodule

>>> rtl/two_class_priority_queue_scheduler_core.sv
// Top level of the two-class strict-priority queue scheduler.
//
//  channel | ports  | handshake         | moves
//  --------+--------+-------------------+------------------------------------------
//  input   | s_*    | s_valid / s_ready | one tick request: arrival flags and ids
//  result  | m_*    | m_valid / m_ready | served entry, event and all counters
//
// Each tick ages every entry queued after the arrivals, one read and one write-back per
// entry through the shared adder; this aging walk sets the length of a tick.
// s_ready is high only between ticks; a result waiting on m_ready holds back the
// end of the next tick, not its start. Reset (aresetn low) empties both queues and
// clears all counters; queue RAMs are not cleared.
`include "two_class_priority_queue_scheduler_core_macros.svh"

module two_class_priority_queue_scheduler_core
    import tcpq_pkg::*;
#(
    parameter int QUEUE_SLOTS = 8
) (
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_high_arrives,
    input  logic [IDENT_W-1:0] s_high_ident,
    input  logic               s_low_arrives,
    input  logic [IDENT_W-1:0] s_low_ident,

    output logic               m_valid,
    input  logic               m_ready,
    output logic [EVENT_W-1:0] m_event_res,
    output logic [IDENT_W-1:0] m_served_ident,
    output logic [WAIT_W-1:0]  m_served_wait,
    output logic [CNT_W-1:0]   m_high_served_total,
    output logic [CNT_W-1:0]   m_low_served_total,
    output logic [CNT_W-1:0]   m_refused_total,
    output logic [CNT_W-1:0]   m_idle_total,
    output logic [CNT_W-1:0]   m_high_wait_sum,
    output logic [CNT_W-1:0]   m_low_wait_sum
);

    localparam int PTR_W = $clog2(QUEUE_SLOTS);
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_SLOTS - 1);

    typedef enum logic [8:0] {
        ST_IDLE     = 9'b000000001,
        ST_SRV_SUM  = 9'b000000010,
        ST_SRV_CNT  = 9'b000000100,
        ST_IDLE_CNT = 9'b000001000,
        ST_PUSH_HI  = 9'b000010000,
        ST_PUSH_LO  = 9'b000100000,
        ST_AGE_RD   = 9'b001000000,
        ST_AGE_WR   = 9'b010000000,
        ST_FIN      = 9'b100000000
    } state_t;

    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
        next_ptr = (p == LAST_SLOT) ? '0 : p + 1'b1;
    endfunction

    state_t state_reg, state_next;

    logic [PTR_W-1:0] hi_head_reg, hi_head_next, hi_tail_reg, hi_tail_next;
    logic [PTR_W-1:0] lo_head_reg, lo_head_next, lo_tail_reg, lo_tail_next;
    logic [PTR_W-1:0] idx_reg, idx_next;
    logic             cls_reg, cls_next;

    logic               in_hi_arr_reg, in_hi_arr_next;
    logic [IDENT_W-1:0] in_hi_id_reg, in_hi_id_next;
    logic               in_lo_arr_reg, in_lo_arr_next;
    logic [IDENT_W-1:0] in_lo_id_reg, in_lo_id_next;

    logic [EVENT_W-1:0] ev_reg, ev_next;
    logic [IDENT_W-1:0] srv_id_reg, srv_id_next;
    logic [WAIT_W-1:0]  srv_wait_reg, srv_wait_next;

    logic [CNT_W-1:0] hi_srv_cnt_reg, hi_srv_cnt_next;
    logic [CNT_W-1:0] lo_srv_cnt_reg, lo_srv_cnt_next;
    logic [CNT_W-1:0] refuse_cnt_reg, refuse_cnt_next;
    logic [CNT_W-1:0] idle_cnt_reg, idle_cnt_next;
    logic [CNT_W-1:0] hi_wsum_reg, hi_wsum_next;
    logic [CNT_W-1:0] lo_wsum_reg, lo_wsum_next;

    logic               m_valid_reg, m_valid_next;
    logic [EVENT_W-1:0] m_event_reg;
    logic [IDENT_W-1:0] m_ident_reg;
    logic [WAIT_W-1:0]  m_wait_reg;
    logic [CNT_W-1:0]   m_hi_srv_reg, m_lo_srv_reg, m_refuse_reg, m_idle_reg;
    logic [CNT_W-1:0]   m_hi_wsum_reg, m_lo_wsum_reg;
    logic               m_load;

    logic               hi_wr_en, hi_rd_en, lo_wr_en, lo_rd_en;
    logic [PTR_W-1:0]   hi_wr_addr, hi_rd_addr, lo_wr_addr, lo_rd_addr;
    logic [ENTRY_W-1:0] hi_wr_data, lo_wr_data, hi_rd_data, lo_rd_data;
    entry_t             rd_entry;

    sat_req_t         add_req;
    logic [CNT_W-1:0] add_sum;

    logic             hi_empty, lo_empty, hi_full, lo_full;
    logic [PTR_W-1:0] cur_tail;

    assign hi_empty = (hi_head_reg == hi_tail_reg);
    assign lo_empty = (lo_head_reg == lo_tail_reg);
    assign hi_full  = (next_ptr(hi_tail_reg) == hi_head_reg);
    assign lo_full  = (next_ptr(lo_tail_reg) == lo_head_reg);
    assign cur_tail = cls_reg ? lo_tail_reg : hi_tail_reg;
    assign rd_entry = entry_t'(cls_reg ? lo_rd_data : hi_rd_data);

    assign s_ready = (state_reg == ST_IDLE);

    tcpq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_SLOTS)
    ) u_hi_ram (
        .clk     (aclk),
        .wr_en   (hi_wr_en),
        .wr_addr (hi_wr_addr),
        .wr_data (hi_wr_data),
        .rd_en   (hi_rd_en),
        .rd_addr (hi_rd_addr),
        .rd_data (hi_rd_data)
    );

    tcpq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_SLOTS)
    ) u_lo_ram (
        .clk     (aclk),
        .wr_en   (lo_wr_en),
        .wr_addr (lo_wr_addr),
        .wr_data (lo_wr_data),
        .rd_en   (lo_rd_en),
        .rd_addr (lo_rd_addr),
        .rd_data (lo_rd_data)
    );

    tcpq_sat_add u_add (
        .req (add_req),
        .sum (add_sum)
    );

    always_comb begin
        state_next      = state_reg;
        hi_head_next    = hi_head_reg;
        hi_tail_next    = hi_tail_reg;
        lo_head_next    = lo_head_reg;
        lo_tail_next    = lo_tail_reg;
        idx_next        = idx_reg;
        cls_next        = cls_reg;
        in_hi_arr_next  = in_hi_arr_reg;
        in_hi_id_next   = in_hi_id_reg;
        in_lo_arr_next  = in_lo_arr_reg;
        in_lo_id_next   = in_lo_id_reg;
        ev_next         = ev_reg;
        srv_id_next     = srv_id_reg;
        srv_wait_next   = srv_wait_reg;
        hi_srv_cnt_next = hi_srv_cnt_reg;
        lo_srv_cnt_next = lo_srv_cnt_reg;
        refuse_cnt_next = refuse_cnt_reg;
        idle_cnt_next   = idle_cnt_reg;
        hi_wsum_next    = hi_wsum_reg;
        lo_wsum_next    = lo_wsum_reg;
        m_load          = 1'b0;

        hi_wr_en   = 1'b0;
        hi_wr_addr = hi_tail_reg;
        hi_wr_data = {in_hi_id_reg, {WAIT_W{1'b0}}};
        hi_rd_en   = 1'b0;
        hi_rd_addr = hi_head_reg;
        lo_wr_en   = 1'b0;
        lo_wr_addr = lo_tail_reg;
        lo_wr_data = {in_lo_id_reg, {WAIT_W{1'b0}}};
        lo_rd_en   = 1'b0;
        lo_rd_addr = lo_head_reg;

        add_req.mode = SAT_CNT;
        add_req.op_a = refuse_cnt_reg;
        add_req.op_b = CNT_W'(1);

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    in_hi_arr_next = s_high_arrives;
                    in_hi_id_next  = s_high_ident;
                    in_lo_arr_next = s_low_arrives;
                    in_lo_id_next  = s_low_ident;
                    hi_rd_en       = 1'b1;
                    lo_rd_en       = 1'b1;
                    cls_next       = hi_empty;
                    state_next     = (hi_empty && lo_empty) ? ST_IDLE_CNT : ST_SRV_SUM;
                end
            end
            ST_SRV_SUM: begin
                add_req.op_a  = cls_reg ? lo_wsum_reg : hi_wsum_reg;
                add_req.op_b  = {{(CNT_W - WAIT_W){1'b0}}, rd_entry.wait_cnt};
                srv_id_next   = rd_entry.ident;
                srv_wait_next = rd_entry.wait_cnt;
                if (cls_reg) begin
                    ev_next      = EVENT_LOW;
                    lo_wsum_next = add_sum;
                    lo_head_next = next_ptr(lo_head_reg);
                end else begin
                    ev_next      = EVENT_HIGH;
                    hi_wsum_next = add_sum;
                    hi_head_next = next_ptr(hi_head_reg);
                end
                state_next = ST_SRV_CNT;
            end
            ST_SRV_CNT: begin
                add_req.op_a = cls_reg ? lo_srv_cnt_reg : hi_srv_cnt_reg;
                if (cls_reg) begin
                    lo_srv_cnt_next = add_sum;
                end else begin
                    hi_srv_cnt_next = add_sum;
                end
                state_next = ST_PUSH_HI;
            end
            ST_IDLE_CNT: begin
                add_req.op_a  = idle_cnt_reg;
                idle_cnt_next = add_sum;
                ev_next       = EVENT_IDLE;
                srv_id_next   = '0;
                srv_wait_next = '0;
                state_next    = ST_PUSH_HI;
            end
            ST_PUSH_HI: begin
                if (in_hi_arr_reg) begin
                    if (hi_full) begin
                        refuse_cnt_next = add_sum;
                    end else begin
                        hi_wr_en     = 1'b1;
                        hi_tail_next = next_ptr(hi_tail_reg);
                    end
                end
                state_next = ST_PUSH_LO;
            end
            ST_PUSH_LO: begin
                if (in_lo_arr_reg) begin
                    if (lo_full) begin
                        refuse_cnt_next = add_sum;
                    end else begin
                        lo_wr_en     = 1'b1;
                        lo_tail_next = next_ptr(lo_tail_reg);
                    end
                end
                cls_next   = 1'b0;
                idx_next   = hi_head_reg;
                state_next = ST_AGE_RD;
            end
            ST_AGE_RD: begin
                hi_rd_addr = idx_reg;
                lo_rd_addr = idx_reg;
                if (idx_reg == cur_tail) begin
                    if (cls_reg) begin
                        state_next = ST_FIN;
                    end else begin
                        cls_next = 1'b1;
                        idx_next = lo_head_reg;
                    end
                end else begin
                    hi_rd_en   = !cls_reg;
                    lo_rd_en   = cls_reg;
                    state_next = ST_AGE_WR;
                end
            end
            ST_AGE_WR: begin
                add_req.mode = SAT_WAIT;
                add_req.op_a = {{(CNT_W - WAIT_W){1'b0}}, rd_entry.wait_cnt};
                hi_wr_addr   = idx_reg;
                lo_wr_addr   = idx_reg;
                hi_wr_data   = {rd_entry.ident, add_sum[WAIT_W-1:0]};
                lo_wr_data   = {rd_entry.ident, add_sum[WAIT_W-1:0]};
                hi_wr_en     = !cls_reg;
                lo_wr_en     = cls_reg;
                idx_next     = next_ptr(idx_reg);
                state_next   = ST_AGE_RD;
            end
            ST_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    m_load     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (m_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            hi_head_reg    <= '0;
            hi_tail_reg    <= '0;
            lo_head_reg    <= '0;
            lo_tail_reg    <= '0;
            hi_srv_cnt_reg <= '0;
            lo_srv_cnt_reg <= '0;
            refuse_cnt_reg <= '0;
            idle_cnt_reg   <= '0;
            hi_wsum_reg    <= '0;
            lo_wsum_reg    <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            hi_head_reg    <= hi_head_next;
            hi_tail_reg    <= hi_tail_next;
            lo_head_reg    <= lo_head_next;
            lo_tail_reg    <= lo_tail_next;
            hi_srv_cnt_reg <= hi_srv_cnt_next;
            lo_srv_cnt_reg <= lo_srv_cnt_next;
            refuse_cnt_reg <= refuse_cnt_next;
            idle_cnt_reg   <= idle_cnt_next;
            hi_wsum_reg    <= hi_wsum_next;
            lo_wsum_reg    <= lo_wsum_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg       <= idx_next;
        cls_reg       <= cls_next;
        in_hi_arr_reg <= in_hi_arr_next;
        in_hi_id_reg  <= in_hi_id_next;
        in_lo_arr_reg <= in_lo_arr_next;
        in_lo_id_reg  <= in_lo_id_next;
        ev_reg        <= ev_next;
        srv_id_reg    <= srv_id_next;
        srv_wait_reg  <= srv_wait_next;
        if (m_load) begin
            m_event_reg   <= ev_reg;
            m_ident_reg   <= srv_id_reg;
            m_wait_reg    <= srv_wait_reg;
            m_hi_srv_reg  <= hi_srv_cnt_reg;
            m_lo_srv_reg  <= lo_srv_cnt_reg;
            m_refuse_reg  <= refuse_cnt_reg;
            m_idle_reg    <= idle_cnt_reg;
            m_hi_wsum_reg <= hi_wsum_reg;
            m_lo_wsum_reg <= lo_wsum_reg;
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_event_res         = m_event_reg;
    assign m_served_ident      = m_ident_reg;
    assign m_served_wait       = m_wait_reg;
    assign m_high_served_total = m_hi_srv_reg;
    assign m_low_served_total  = m_lo_srv_reg;
    assign m_refused_total     = m_refuse_reg;
    assign m_idle_total        = m_idle_reg;
    assign m_high_wait_sum     = m_hi_wsum_reg;
    assign m_low_wait_sum      = m_lo_wsum_reg;

    `TCPQ_ASSERT(a_busy_after_accept, aclk, aresetn, (s_valid && s_ready) |=> !s_ready, "accepted a request while busy")
    `TCPQ_ASSERT(a_low_only_if_high_empty, aclk, aresetn, ((state_reg == ST_SRV_SUM) && cls_reg) |-> hi_empty, "low class served with high entries queued")
    `TCPQ_NEVER(a_age_in_window, aclk, aresetn, (state_reg == ST_AGE_WR) && (idx_reg == cur_tail), "aging wrote a free slot")
    `TCPQ_ASSERT(a_idle_result_clean, aclk, aresetn, (m_valid && (m_event_res == EVENT_IDLE)) |-> ((m_served_ident == '0) && (m_served_wait == '0)), "idle result carries an entry")

endmodule
